// File: rtl/wal_pkg.sv
// Shared types, timing constants and rate tables of the airtime link metric.
`default_nettype none

package wal_pkg;

  typedef struct packed {
    logic [11:0] frame_octets;
    logic [4:0]  retry_count;
    logic        tx_failed;
    logic [2:0]  rate_index;
  } wal_item_t;

  localparam logic [15:0] RTS_THRESHOLD_RESET = 16'd2347;

  localparam int LEN_CRC           = 4;
  localparam int HDR_TOTAL         = 60;
  localparam int SERVICE_TAIL_BITS = 22;
  localparam int PREAMBLE_US       = 20;
  localparam int T_SIFS            = 16;
  localparam int T_DIFS            = 34;
  localparam int T_ACK_TIMEOUT     = 50;
  localparam int RTS_CTS_US        = 128;

  localparam int SUM_WIDTH   = 48;
  localparam int AIR_WIDTH   = 24;
  localparam int Q_WIDTH     = 24;
  localparam int TOTAL_WIDTH = 32;
  localparam int FRAC_SHIFT  = 17;
  localparam int PRE_SHIFT   = Q_WIDTH - FRAC_SHIFT;

  function automatic logic [7:0] bits_per_symbol(input logic [2:0] rate);
    logic [7:0] nd;
    unique case (rate)
      3'd0:    nd = 8'd24;
      3'd1:    nd = 8'd36;
      3'd2:    nd = 8'd48;
      3'd3:    nd = 8'd72;
      3'd4:    nd = 8'd96;
      3'd5:    nd = 8'd144;
      3'd6:    nd = 8'd192;
      default: nd = 8'd216;
    endcase
    return nd;
  endfunction

  // ACK of 14 octets sent at 6, 12 or 24 Mb/s depending on the data rate.
  function automatic logic [5:0] ack_time_us(input logic [2:0] rate);
    logic [5:0] t;
    unique case (rate)
      3'd0, 3'd1: t = 6'd44;
      3'd2, 3'd3: t = 6'd32;
      default:    t = 6'd28;
    endcase
    return t;
  endfunction

  // Contention window times 9 half microseconds for backoff stages 0 to 9.
  function automatic logic [13:0] backoff_half_us(input logic [3:0] stage);
    logic [13:0] t;
    unique case (stage)
      4'd0:    t = 14'd135;
      4'd1:    t = 14'd279;
      4'd2:    t = 14'd567;
      4'd3:    t = 14'd1143;
      4'd4:    t = 14'd2295;
      4'd5:    t = 14'd4599;
      default: t = 14'd9207;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/wal_serial_mult.sv
// Shift-add multiplier that retires one multiplier bit per cycle.
`default_nettype none

module wal_serial_mult
  import wal_pkg::*;
#(
  parameter int A_WIDTH = 32,
  parameter int B_WIDTH = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [A_WIDTH-1:0]         a_i,
  input  logic [B_WIDTH-1:0]         b_i,
  output logic                       done_o,
  output logic [A_WIDTH+B_WIDTH-1:0] product_o
);

  localparam int P_WIDTH = A_WIDTH + B_WIDTH;
  localparam int CNT_W   = $clog2(A_WIDTH);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [B_WIDTH-1:0] b_q, b_d;
  logic [P_WIDTH-1:0] prod_q, prod_d;
  logic [B_WIDTH:0]   sum;

  always_comb begin
    sum = {1'b0, prod_q[P_WIDTH-1:A_WIDTH]} + (prod_q[0] ? {1'b0, b_q} : '0);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    b_d    = b_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      b_d    = b_i;
      prod_d = {{B_WIDTH{1'b0}}, a_i};
    end else if (busy_q) begin
      prod_d = {sum, prod_q[A_WIDTH-1:1]};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(A_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q    <= b_d;
    prod_q <= prod_d;
  end

  assign done_o    = done_q;
  assign product_o = prod_q;

endmodule

`default_nettype wire

// File: rtl/wal_airtime.sv
// Per-packet airtime: serial symbol count division, then one attempt per cycle.
`default_nettype none

module wal_airtime
  import wal_pkg::*;
#(
  parameter int MAX_RETRIES = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  wal_item_t            item_i,
  input  logic [15:0]          rts_threshold_i,
  output logic                 done_o,
  output logic [AIR_WIDTH-1:0] air_o
);

  localparam int AW = $clog2(MAX_RETRIES + 1);
  localparam int RW = (AW > 5) ? AW : 5;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_DIV  = 4'b0010,
    A_COST = 4'b0100,
    A_LOOP = 4'b1000
  } air_state_e;

  air_state_e           state_q, state_d;
  logic                 done_q, done_d;
  logic [3:0]           cnt_q, cnt_d;
  logic [7:0]           rem_q, rem_d;
  logic [15:0]          dvd_q, dvd_d;
  logic [15:0]          fail_hus_q, fail_hus_d;
  logic [15:0]          succ_hus_q, succ_hus_d;
  logic [AW-1:0]        att_q, att_d;
  logic [AW-1:0]        last_q, last_d;
  logic [3:0]           stage_q, stage_d;
  logic [AIR_WIDTH-1:0] air_q, air_d;

  logic [7:0]  nd;
  logic [8:0]  trial;
  logic        ge;
  logic [12:0] frame;
  logic        rts_on;
  logic [14:0] base_us;
  logic [14:0] fail_us;
  logic [14:0] succ_us;
  logic [RW-1:0] retry_ext;
  logic        last_ok;
  logic [15:0] attempt_hus;

  always_comb begin
    nd          = bits_per_symbol(item_i.rate_index);
    trial       = {rem_q, dvd_q[15]};
    ge          = trial >= {1'b0, nd};
    frame       = {1'b0, item_i.frame_octets} + 13'(LEN_CRC);
    rts_on      = rts_threshold_i <= {3'b000, frame};
    base_us     = 15'(PREAMBLE_US) + {dvd_q[12:0], 2'b00}
                  + (rts_on ? 15'(RTS_CTS_US) : 15'd0);
    fail_us     = base_us + 15'(T_SIFS + T_ACK_TIMEOUT + T_DIFS);
    succ_us     = base_us + 15'(T_SIFS + T_DIFS) + 15'(ack_time_us(item_i.rate_index));
    retry_ext   = RW'(item_i.retry_count);
    last_ok     = (att_q == last_q) && !item_i.tx_failed;
    attempt_hus = last_ok ? succ_hus_q : fail_hus_q;

    state_d    = state_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    fail_hus_d = fail_hus_q;
    succ_hus_d = succ_hus_q;
    att_d      = att_q;
    last_d     = last_q;
    stage_d    = stage_q;
    air_d      = air_q;

    unique case (state_q)
      A_IDLE: begin
        if (start_i) begin
          dvd_d   = 16'({item_i.frame_octets, 3'b000})
                    + 16'(SERVICE_TAIL_BITS + 8 * LEN_CRC - 1) + 16'(nd);
          rem_d   = '0;
          cnt_d   = '0;
          air_d   = '0;
          att_d   = '0;
          stage_d = '0;
          last_d  = (retry_ext > RW'(MAX_RETRIES)) ? AW'(MAX_RETRIES) : AW'(retry_ext);
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        rem_d = ge ? 8'(trial - {1'b0, nd}) : trial[7:0];
        dvd_d = {dvd_q[14:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd15) begin
          state_d = A_COST;
        end
      end
      A_COST: begin
        fail_hus_d = {fail_us, 1'b0};
        succ_hus_d = {succ_us, 1'b0};
        state_d    = A_LOOP;
      end
      A_LOOP: begin
        air_d   = air_q + AIR_WIDTH'(backoff_half_us(stage_q)) + AIR_WIDTH'(attempt_hus);
        att_d   = att_q + 1'b1;
        stage_d = (stage_q == 4'd9) ? 4'd0 : stage_q + 4'd1;
        if (att_q == last_q) begin
          done_d  = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      att_q   <= '0;
      last_q  <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
      att_q   <= att_d;
      last_q  <= last_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    fail_hus_q <= fail_hus_d;
    succ_hus_q <= succ_hus_d;
    air_q      <= air_d;
  end

  assign done_o = done_q;
  assign air_o  = air_q;

  a_attempt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == A_LOOP) |-> (att_q <= last_q))
    else $error("Attempt counter passed the last attempt.");

endmodule

`default_nettype wire

// File: rtl/wal_divider.sv
// Restoring divider for the saturated Q7.17 throughput quotient, one bit per cycle.
`default_nettype none

module wal_divider
  import wal_pkg::*;
#(
  parameter int NUM_WIDTH = 80,
  parameter int DEN_WIDTH = 81
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [NUM_WIDTH-1:0] num_i,
  input  logic [DEN_WIDTH-1:0] den_i,
  output logic                 done_o,
  output logic [Q_WIDTH-1:0]   quot_o
);

  localparam int RW    = DEN_WIDTH + 1;
  localparam int CNT_W = $clog2(Q_WIDTH);

  typedef enum logic [2:0] {
    D_IDLE   = 3'b001,
    D_CHECK  = 3'b010,
    D_DIVIDE = 3'b100
  } div_state_e;

  div_state_e           state_q, state_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [DEN_WIDTH-1:0] den_q, den_d;
  logic [RW-1:0]        r_q, r_d;
  logic [Q_WIDTH-1:0]   lo_q, lo_d;
  logic [Q_WIDTH-1:0]   quot_q, quot_d;

  logic [RW-1:0] den_ext;
  logic [RW-1:0] trial;
  logic          ge;

  always_comb begin
    den_ext = {1'b0, den_q};
    trial   = {r_q[RW-2:0], lo_q[Q_WIDTH-1]};
    ge      = trial >= den_ext;

    state_d = state_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    den_d   = den_q;
    r_d     = r_q;
    lo_d    = lo_q;
    quot_d  = quot_q;

    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          den_d   = den_i;
          r_d     = RW'(num_i >> PRE_SHIFT);
          lo_d    = {num_i[PRE_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
          state_d = D_CHECK;
        end
      end
      D_CHECK: begin
        cnt_d = '0;
        if (den_q == '0) begin
          quot_d  = '0;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else if (r_q >= den_ext) begin
          quot_d  = '1;
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          state_d = D_DIVIDE;
        end
      end
      D_DIVIDE: begin
        r_d    = ge ? trial - den_ext : trial;
        quot_d = {quot_q[Q_WIDTH-2:0], ge};
        lo_d   = {lo_q[Q_WIDTH-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(Q_WIDTH - 1)) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    r_q    <= r_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_remainder_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == D_DIVIDE) |-> (r_q < {1'b0, den_q}))
    else $error("Partial remainder reached the divisor.");

endmodule

`default_nettype wire

// File: rtl/wifi_airtime_link_metric.sv
// Top level of the airtime link metric: stream ports, running totals and sequencing.
//
// One input beat reports one transmitted 802.11a packet: frame length, retry
// count and rate in s_axis_tdata, the final failure flag in s_axis_tuser. The
// block charges the packet's airtime, updates its saturating totals and
// returns one output beat with the link throughput, the packet's airtime and
// the success count. The rts_threshold register is written on the cfg channel,
// which is always ready; the user must write it only while no packet is in
// flight, as the block itself does not enforce this. From input beat to output
// beat a packet passes the serial symbol count division, the airtime loop with
// one attempt per cycle, the two bit-serial multipliers and the bit-serial
// quotient. One packet is in work at a time; s_axis_tready is high only between
// packets. A finished result sits in the output register, so the next packet is
// taken while it waits; if the receiver still stalls when that packet is done,
// the block holds it until the output register frees. Reset clears all totals,
// sets rts_threshold to 2347 and empties the output register.
`default_nettype none

module wifi_airtime_link_metric
  import wal_pkg::*;
#(
  parameter int MAX_RETRIES = 31,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // frame_octets [11:0], retry_count [16:12], rate_index [19:17], zero [23:20]
  input  logic [23:0] s_axis_tdata,
  // tx_failed [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // throughput_q17 [23:0], packet_airtime [47:24], success_total [79:48]
  output logic [79:0] m_axis_tdata
);

  localparam int SUM_EXT = SUM_WIDTH + 1;
  localparam int OUT_W   = Q_WIDTH + AIR_WIDTH + TOTAL_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_AIR  = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } top_state_e;

  top_state_e             state_q, state_d;
  logic [15:0]            rts_threshold_q;
  logic [COUNT_WIDTH-1:0] success_count_q, success_count_d;
  logic [COUNT_WIDTH-1:0] packet_total_q, packet_total_d;
  logic [SUM_WIDTH-1:0]   payload_sum_q, payload_sum_d;
  logic [SUM_WIDTH-1:0]   success_air_q, success_air_d;
  logic [SUM_WIDTH-1:0]   failure_air_q, failure_air_d;
  logic                   air_start_q, air_start_d;
  logic                   mul_start_q, mul_start_d;
  logic                   div_start_q, div_start_d;
  logic                   out_valid_q, out_valid_d;
  logic [OUT_W-1:0]       out_data_q;
  wal_item_t              item_q;

  logic                   in_accept;
  logic                   out_free;
  logic                   out_load;
  logic                   air_done;
  logic [AIR_WIDTH-1:0]   air;
  logic                   num_done;
  logic                   den_done;
  logic [COUNT_WIDTH+SUM_WIDTH-1:0] num;
  logic [COUNT_WIDTH+SUM_WIDTH:0]   den;
  logic [SUM_WIDTH:0]     air_sum;
  logic                   div_done;
  logic [Q_WIDTH-1:0]     quot;
  logic [11:0]            payload_add;
  logic [SUM_EXT-1:0]     ps_sum;
  logic [SUM_EXT-1:0]     sa_sum;
  logic [SUM_EXT-1:0]     fa_sum;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign out_load      = (state_q == S_OUT) && out_free;
  assign air_sum       = {1'b0, success_air_q} + {1'b0, failure_air_q};

  wal_airtime #(
    .MAX_RETRIES(MAX_RETRIES)
  ) u_airtime (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (air_start_q),
    .item_i         (item_q),
    .rts_threshold_i(rts_threshold_q),
    .done_o         (air_done),
    .air_o          (air)
  );

  wal_serial_mult #(
    .A_WIDTH(COUNT_WIDTH),
    .B_WIDTH(SUM_WIDTH)
  ) u_num_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .a_i      (success_count_q),
    .b_i      (payload_sum_q),
    .done_o   (num_done),
    .product_o(num)
  );

  wal_serial_mult #(
    .A_WIDTH(COUNT_WIDTH),
    .B_WIDTH(SUM_EXT)
  ) u_den_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .a_i      (packet_total_q),
    .b_i      (air_sum),
    .done_o   (den_done),
    .product_o(den)
  );

  wal_divider #(
    .NUM_WIDTH(COUNT_WIDTH + SUM_WIDTH),
    .DEN_WIDTH(COUNT_WIDTH + SUM_EXT)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    payload_add = (item_q.frame_octets > 12'(HDR_TOTAL))
                  ? item_q.frame_octets - 12'(HDR_TOTAL) : 12'd0;
    ps_sum = {1'b0, payload_sum_q} + SUM_EXT'(payload_add);
    sa_sum = {1'b0, success_air_q} + SUM_EXT'(air);
    fa_sum = {1'b0, failure_air_q} + SUM_EXT'(air);

    state_d         = state_q;
    success_count_d = success_count_q;
    packet_total_d  = packet_total_q;
    payload_sum_d   = payload_sum_q;
    success_air_d   = success_air_q;
    failure_air_d   = failure_air_q;
    air_start_d     = 1'b0;
    mul_start_d     = 1'b0;
    div_start_d     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          air_start_d = 1'b1;
          state_d     = S_AIR;
        end
      end
      S_AIR: begin
        if (air_done) begin
          payload_sum_d  = ps_sum[SUM_WIDTH] ? '1 : ps_sum[SUM_WIDTH-1:0];
          packet_total_d = (&packet_total_q) ? packet_total_q
                                             : packet_total_q + COUNT_WIDTH'(1);
          if (item_q.tx_failed) begin
            failure_air_d = fa_sum[SUM_WIDTH] ? '1 : fa_sum[SUM_WIDTH-1:0];
          end else begin
            success_air_d   = sa_sum[SUM_WIDTH] ? '1 : sa_sum[SUM_WIDTH-1:0];
            success_count_d = (&success_count_q) ? success_count_q
                                                 : success_count_q + COUNT_WIDTH'(1);
          end
          mul_start_d = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        if (num_done && den_done) begin
          div_start_d = 1'b1;
          state_d     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = (out_valid_q && !m_axis_tready) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      rts_threshold_q <= RTS_THRESHOLD_RESET;
      success_count_q <= '0;
      packet_total_q  <= '0;
      payload_sum_q   <= '0;
      success_air_q   <= '0;
      failure_air_q   <= '0;
      air_start_q     <= 1'b0;
      mul_start_q     <= 1'b0;
      div_start_q     <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rts_threshold_q <= cfg_data_i;
      end
      success_count_q <= success_count_d;
      packet_total_q  <= packet_total_d;
      payload_sum_q   <= payload_sum_d;
      success_air_q   <= success_air_d;
      failure_air_q   <= failure_air_d;
      air_start_q     <= air_start_d;
      mul_start_q     <= mul_start_d;
      div_start_q     <= div_start_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.frame_octets <= s_axis_tdata[11:0];
      item_q.retry_count  <= s_axis_tdata[16:12];
      item_q.rate_index   <= s_axis_tdata[19:17];
      item_q.tx_failed    <= s_axis_tuser;
    end
    if (out_load) begin
      out_data_q <= {TOTAL_WIDTH'(success_count_q), air, quot};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_successes_within_packets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    success_count_q <= packet_total_q)
    else $error("Success count exceeds packet count.");

  a_accept_starts_airtime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_AIR) && air_start_q)
    else $error("Accepted beat did not start the airtime unit.");

  a_output_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !out_free |=> (state_q == S_OUT))
    else $error("Result left while the output register was occupied.");

endmodule

`default_nettype wire
